### rtl/trsg_pkg.sv
`default_nettype none
package trsg_pkg;
  localparam int HistoryDepth = 16;
  localparam int SlotW = $clog2(HistoryDepth);
  localparam int CountW = $clog2(HistoryDepth + 1);
  localparam int PosW = 24;
  localparam int TimeW = 32;
  localparam int EntryW = 2 * PosW + TimeW;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 23;
  localparam int MulAW = 96;
  localparam int MulBW = 64;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [CfgIdxW-1:0] REG_RANGE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FORWARD_MIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED_MIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_MAX   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STALE_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPAN_MIN    = 3'd5;

  localparam logic [2:0] RSN_OK    = 3'd0;
  localparam logic [2:0] RSN_NONE  = 3'd1;
  localparam logic [2:0] RSN_STALE = 3'd2;
  localparam logic [2:0] RSN_POSE  = 3'd3;
  localparam logic [2:0] RSN_RANGE = 3'd4;
  localparam logic [2:0] RSN_SLOW  = 3'd5;
  localparam logic [2:0] RSN_FAST  = 3'd6;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [TimeW-1:0]       t;
  } entry_t;

  typedef struct packed {
    logic [22:0] range_limit;
    logic [22:0] forward_min;
    logic [15:0] speed_min;
    logic [15:0] speed_max;
    logic [15:0] stale_limit;
    logic [15:0] span_min;
  } cfg_t;
endpackage
`default_nettype wire

### rtl/trsg_store.sv
`default_nettype none
module trsg_store (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [trsg_pkg::SlotW-1:0] waddr,
  input  wire trsg_pkg::entry_t      wdata,
  input  wire logic [trsg_pkg::SlotW-1:0] raddr,
  output trsg_pkg::entry_t           rdata
);
  import trsg_pkg::*;
  entry_t mem [HistoryDepth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/trsg_cfg.sv
`default_nettype none
module trsg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [trsg_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [trsg_pkg::CfgDataW-1:0]  cfg_data,
  output trsg_pkg::cfg_t                      cfg
);
  import trsg_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_limit <= 23'd5120;
      cfg.forward_min <= 23'd1280;
      cfg.speed_min   <= 16'd77;
      cfg.speed_max   <= 16'd2048;
      cfg.stale_limit <= 16'd3000;
      cfg.span_min    <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LIMIT: cfg.range_limit <= cfg_data;
        REG_FORWARD_MIN: cfg.forward_min <= cfg_data;
        REG_SPEED_MIN:   cfg.speed_min   <= cfg_data[15:0];
        REG_SPEED_MAX:   cfg.speed_max   <= cfg_data[15:0];
        REG_STALE_LIMIT: cfg.stale_limit <= cfg_data[15:0];
        REG_SPAN_MIN:    cfg.span_min    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/target_range_speed_gate.sv
// Channel | Signals                                        | Direction
// in      | in_valid/in_ready, mode pos_x pos_y time_ms    | into block
//         | quat_w quat_x quat_y quat_z pose_valid         |
// out     | out_valid/out_ready, pass reason               | out of block
// cfg     | cfg_we, cfg_index, cfg_data                    | into block
// A store word is written on accept; the input is ready again the next cycle.
// An evaluate word gives its result after two reads of the
// history memory, short arithmetic, then five wide products on one shared
// 32x32 multiplier (six partial products each).
// One evaluate is in work at a time; a result waiting in the output register
// holds only the next evaluate result. Reset clears slot pointer and entry count.
`default_nettype none
module target_range_speed_gate (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              mode,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic [31:0]       time_ms,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic              pose_valid,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   pass,
  output logic [2:0]             reason,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [22:0]       cfg_data
);
  import trsg_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDN  = 4'd1;
  localparam logic [3:0] ST_RDO  = 4'd2;
  localparam logic [3:0] ST_A    = 4'd3;
  localparam logic [3:0] ST_B    = 4'd4;
  localparam logic [3:0] ST_C    = 4'd5;
  localparam logic [3:0] ST_D    = 4'd6;
  localparam logic [3:0] ST_W1   = 4'd7;
  localparam logic [3:0] ST_W2   = 4'd8;
  localparam logic [3:0] ST_W3   = 4'd9;
  localparam logic [3:0] ST_W4   = 4'd10;
  localparam logic [3:0] ST_W5   = 4'd11;
  localparam logic [3:0] ST_E    = 4'd12;
  localparam logic [3:0] ST_F    = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  localparam logic [MulBW-1:0] SpeedScale = 64'd1000000;

  cfg_t cfg;

  logic [3:0] state;
  logic [SlotW-1:0] write_slot;
  logic [CountW-1:0] entry_count;
  logic [SlotW-1:0] raddr;
  entry_t rdata, wdata;
  logic we;
  logic in_acc;
  logic res_load;
  logic [SlotW-1:0] newest_i, oldest_i;

  logic signed [23:0] bx, by;
  logic [31:0] now;
  logic signed [15:0] qw, qx, qy, qz;
  logic pv;
  entry_t nw;
  logic [2:0] rsn;
  logic rsn_set;

  // arithmetic registers
  logic signed [31:0] m1, m2;
  logic signed [33:0] s_r, c_r;
  logic signed [24:0] dx, dy;
  logic [50:0] d2;
  logic signed [60:0] p;
  logic [67:0] cs2;
  logic [45:0] fm2;
  logic [121:0] lhs, rhs;
  logic [31:0] span;
  logic [50:0] e2;
  logic [95:0] moved;
  logic [47:0] lo_lim, hi_lim;
  logic [95:0] lo2, hi2;
  logic signed [24:0] ex, ey;

  logic mul_start, mul_done;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_prod;

  trsg_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  assign in_ready = (state == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign we = in_acc && !mode;
  assign wdata = '{x: pos_x, y: pos_y, t: time_ms};
  assign res_load = (state == ST_DONE) && (!out_valid || out_ready);

  assign newest_i = write_slot - SlotW'(1);
  assign oldest_i = (entry_count < CountW'(HistoryDepth)) ? '0 : write_slot;

  always_comb begin
    raddr = write_slot;
    case (state)
      ST_RDN:  raddr = newest_i;
      ST_RDO:  raddr = oldest_i;
      default: raddr = write_slot;
    endcase
  end

  trsg_store u_store (.clk, .we, .waddr(write_slot), .wdata, .raddr, .rdata);

  assign mul_start = (state == ST_D) || (mul_done && (state == ST_W1 || state == ST_W2 ||
                     state == ST_W3 || state == ST_W4));

  always_comb begin
    case (state)
      ST_D: begin
        mul_a = MulAW'($unsigned(p));
        mul_b = MulBW'($unsigned(p));
      end
      ST_W1: begin
        mul_a = MulAW'(cs2);
        mul_b = MulBW'(fm2);
      end
      ST_W2: begin
        mul_a = MulAW'(e2);
        mul_b = SpeedScale;
      end
      ST_W3: begin
        mul_a = MulAW'(lo_lim);
        mul_b = MulBW'(lo_lim);
      end
      ST_W4: begin
        mul_a = MulAW'(hi_lim);
        mul_b = MulBW'(hi_lim);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  trsg_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done),
                  .prod(mul_prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      write_slot <= '0;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (!mode) begin
              write_slot <= write_slot + SlotW'(1);
              if (entry_count < CountW'(HistoryDepth)) begin
                entry_count <= entry_count + CountW'(1);
              end
            end else begin
              state <= ST_RDN;
            end
          end
        end
        ST_W1, ST_W2, ST_W3, ST_W4, ST_W5: begin
          if (mul_done) begin
            state <= state + 4'd1;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= state + 4'd1;
      endcase
    end
  end

  // datapath: one short step per state, wide products on the shared multiplier
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bx <= pos_x; by <= pos_y; now <= time_ms; pv <= pose_valid;
        qw <= quat_w; qx <= quat_x; qy <= quat_y; qz <= quat_z;
        rsn_set <= 1'b0; rsn <= RSN_OK;
      end
      ST_RDN: begin
        m1 <= qw * qz; m2 <= qx * qy;
      end
      ST_RDO: begin
        nw <= rdata;
        s_r <= 34'(2 * (35'(m1) + 35'(m2)));
        m1 <= qy * qy; m2 <= qz * qz;
        if (entry_count == '0) begin
          rsn <= RSN_NONE; rsn_set <= 1'b1;
        end
      end
      ST_A: begin
        c_r <= 34'sd268435456 - 34'(2 * (35'(m1) + 35'(m2)));
        dx <= 25'(nw.x) - 25'(bx);
        dy <= 25'(nw.y) - 25'(by);
        span <= nw.t - rdata.t;
        ex <= 25'(nw.x) - 25'(rdata.x);
        ey <= 25'(nw.y) - 25'(rdata.y);
        if (!rsn_set) begin
          if ((now - nw.t) > 32'(cfg.stale_limit)) begin
            rsn <= RSN_STALE; rsn_set <= 1'b1;
          end else if (!pv) begin
            rsn <= RSN_POSE; rsn_set <= 1'b1;
          end
        end
      end
      ST_B: begin
        d2 <= 51'(dx * dx) + 51'(dy * dy);
        e2 <= 51'(ex * ex) + 51'(ey * ey);
        fm2 <= 46'(cfg.forward_min * cfg.forward_min);
      end
      ST_C: begin
        if (!rsn_set && d2 > 51'(cfg.range_limit * cfg.range_limit)) begin
          rsn <= RSN_RANGE; rsn_set <= 1'b1;
        end
        p <= 61'(c_r * dx) + 61'(s_r * dy);
        cs2 <= 68'(c_r * c_r) + 68'(s_r * s_r);
      end
      ST_D: begin
        lo_lim <= 48'(cfg.speed_min * span);
        hi_lim <= 48'(cfg.speed_max * span);
      end
      ST_W1: if (mul_done) lhs <= mul_prod[121:0];
      ST_W2: if (mul_done) rhs <= mul_prod[121:0];
      ST_W3: if (mul_done) moved <= mul_prod[95:0];
      ST_W4: if (mul_done) lo2 <= mul_prod[95:0];
      ST_W5: if (mul_done) hi2 <= mul_prod[95:0];
      ST_E: begin
        if (!rsn_set) begin
          if (s_r == 0 && c_r == 0) begin
            if (dx < $signed({2'b00, cfg.forward_min})) begin
              rsn <= RSN_RANGE; rsn_set <= 1'b1;
            end
          end else if (p < 0 || lhs < rhs) begin
            rsn <= RSN_RANGE; rsn_set <= 1'b1;
          end
        end
      end
      ST_F: begin
        if (!rsn_set && entry_count >= CountW'(2) && span > 32'(cfg.span_min)) begin
          if (moved < lo2) begin
            rsn <= RSN_SLOW; rsn_set <= 1'b1;
          end else if (moved > hi2) begin
            rsn <= RSN_FAST; rsn_set <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pass <= (rsn == RSN_OK);
      reason <= rsn;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_result_after_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> out_valid) else $error("result lost");
  a_store_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !mode) |=> (state == ST_IDLE)) else $error("store stalled");
  a_pass_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pass == (reason == RSN_OK))) else $error("pass mismatch");
`endif
endmodule

module trsg_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [trsg_pkg::MulAW-1:0]  a,
  input  wire logic [trsg_pkg::MulBW-1:0]  b,
  output logic                             done,
  output logic [trsg_pkg::MulPW-1:0]       prod
);
  import trsg_pkg::*;

  logic [MulAW-1:0] a_r;
  logic [MulBW-1:0] b_r;
  logic [1:0] ai;
  logic bi;
  logic busy;
  logic last;
  logic [31:0] a_dig, b_dig;
  logic [63:0] part;
  logic [2:0] shift;

  always_comb begin
    case (ai)
      2'd0:    a_dig = a_r[31:0];
      2'd1:    a_dig = a_r[63:32];
      default: a_dig = a_r[95:64];
    endcase
  end

  assign b_dig = bi ? b_r[63:32] : b_r[31:0];
  assign part = {32'd0, a_dig} * {32'd0, b_dig};
  assign shift = {1'b0, ai} + {2'b00, bi};
  assign last = (ai == 2'd2) && bi;

  // accumulate one 32x32 partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ai <= '0;
      bi <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        a_r <= a;
        b_r <= b;
        prod <= '0;
        ai <= '0;
        bi <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + (MulPW'(part) << {shift, 5'd0});
        if (last) begin
          busy <= 1'b0;
        end else if (ai == 2'd2) begin
          ai <= '0;
          bi <= 1'b1;
        end else begin
          ai <= ai + 2'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire
